@@ hdl/rvnp_pkg.sv @@
// Shared constants, types and codes for the RTP video NAL packetizer.
package rvnp_pkg;

  localparam int PAYLOAD_MTU = 1400;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

  localparam logic [10:0] MAXF_H264 = 11'(PAYLOAD_MTU - 2);
  localparam logic [10:0] MAXF_H265 = 11'(PAYLOAD_MTU - 3);

  localparam logic [3:0] POS_LAST_HDR = 4'd11;
  localparam logic [3:0] POS_DATA     = 4'd15;

  localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
  localparam logic [7:0] H265_FU_TYPE     = 8'h62;
  localparam logic [4:0] H264_FU_A_TYPE   = 5'd28;

  typedef enum logic [2:0] {
    CFG_SSRC         = 3'd0,
    CFG_INITIAL_SEQ  = 3'd1,
    CFG_INITIAL_TS   = 3'd2,
    CFG_TS_INCREMENT = 3'd3,
    CFG_USE_H265     = 3'd4,
    CFG_PAYLOAD_TYPE = 3'd5
  } cfg_index_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SCAN,
    PH_DRAIN,
    PH_BODY
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       hdr;
    logic       marker;
    logic [1:0] fu_n;
    logic [7:0] fu0;
    logic [7:0] fu1;
    logic [7:0] fu2;
    logic       eop;
    logic       eor;
    logic       ts_step;
  } cmd_t;

  typedef struct packed {
    logic        seq_load;
    logic [15:0] seq_value;
    logic        ts_load;
    logic [31:0] ts_value;
  } cnt_load_t;

endpackage

@@ hdl/rvnp_front.sv @@
// Front part: start code strip, fragmentation decisions, command generation.
module rvnp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        nal_byte,
  input  logic [19:0]       nal_length,
  input  logic              first_of_nal,
  input  logic              use_h265,
  input  logic              fifo_full,
  output logic              push,
  output rvnp_pkg::cmd_t    cmd
);

  rvnp_pkg::phase_t phase, phase_next;
  logic [19:0] nal_total, nal_total_next;
  logic [2:0]  pos, pos_next;
  logic [7:0]  held [4];
  logic [7:0]  held_next [4];
  logic [2:0]  strip, strip_next;
  logic [2:0]  di, di_next;
  logic        is265, is265_next;
  logic        frag, frag_next;
  logic [19:0] payload_left, payload_left_next;
  logic [10:0] frag_left, frag_left_next;
  logic        first_frag, first_frag_next;
  logic [7:0]  nh0, nh0_next, nh1, nh1_next;
  logic [1:0]  idx, idx_next;

  logic        acc;
  logic        feed_en;
  logic [7:0]  feed_b;
  logic [1:0]  feed_idx;
  logic        feed_eor;
  logic        hdr_byte;
  logic [10:0] maxf;
  logic        new_frag;
  logic        last_frag;
  logic [10:0] fl_new, fl_dec;
  logic [19:0] pl_dec;
  logic        nal_done;
  logic [7:0]  flags;
  logic [2:0]  sp;
  logic [19:0] st;
  logic [2:0]  p;
  logic [7:0]  hw [4];
  logic        dec_ok;
  logic [2:0]  dec_s;
  logic [19:0] size;
  logic [2:0]  dd;

  assign in_stall = fifo_full || (phase == rvnp_pkg::PH_DRAIN);
  assign acc      = in_valid && !in_stall;

  // feed unit
  always_comb begin
    hdr_byte  = frag && (feed_idx < (is265 ? 2'd2 : 2'd1));
    maxf      = is265 ? rvnp_pkg::MAXF_H265 : rvnp_pkg::MAXF_H264;
    new_frag  = (frag_left == 11'd0);
    last_frag = (payload_left <= {9'd0, maxf});
    fl_new    = new_frag ? (last_frag ? payload_left[10:0] : maxf) : frag_left;
    fl_dec    = fl_new - 11'd1;
    pl_dec    = payload_left - 20'd1;
    nal_done  = feed_en && !hdr_byte && (pl_dec == 20'd0);
    flags     = {first_frag, last_frag, 6'd0};
    push      = feed_en && !hdr_byte;
    cmd       = '0;
    cmd.data    = feed_b;
    cmd.eor     = feed_eor || nal_done;
    cmd.ts_step = (pl_dec == 20'd0);
    if (!frag) begin
      cmd.hdr    = (feed_idx == 2'd0);
      cmd.marker = 1'b1;
      cmd.eop    = (payload_left == 20'd1);
    end else begin
      cmd.eop = (fl_dec == 11'd0);
      if (new_frag) begin
        cmd.hdr    = 1'b1;
        cmd.marker = last_frag;
        if (is265) begin
          cmd.fu_n = 2'd3;
          cmd.fu0  = rvnp_pkg::H265_FU_TYPE | (nh0 & 8'h81);
          cmd.fu1  = nh1;
          cmd.fu2  = {flags[7:6], nh0[6:1]};
        end else begin
          cmd.fu_n = 2'd2;
          cmd.fu1  = {nh0[7:5], rvnp_pkg::H264_FU_A_TYPE};
          cmd.fu2  = {flags[7:6], 1'b0, nh0[4:0]};
        end
      end
    end
  end

  // start code decision on held bytes with the incoming byte written
  always_comb begin
    sp = first_of_nal ? 3'd0 : pos;
    st = first_of_nal ? nal_length : nal_total;
    for (int i = 0; i < 4; i++) begin
      hw[i] = held[i];
    end
    hw[sp[1:0]] = nal_byte;
    p      = sp + 3'd1;
    dec_ok = 1'b1;
    dec_s  = 3'd0;
    if (hw[0] != 8'd0) begin
      dec_s = 3'd0;
    end else if (p >= 3'd2 && hw[1] != 8'd0) begin
      dec_s = 3'd0;
    end else if (p >= 3'd3 && hw[2] == 8'd1) begin
      dec_s = 3'd3;
    end else if (p >= 3'd3 && hw[2] != 8'd0) begin
      dec_s = 3'd0;
    end else if (p >= 3'd4) begin
      dec_s = (hw[3] == 8'd1) ? 3'd4 : 3'd0;
    end else if ({17'd0, p} >= st) begin
      dec_s = 3'd0;
    end else begin
      dec_ok = 1'b0;
    end
    size = st - {17'd0, dec_s};
  end

  always_comb begin
    phase_next        = phase;
    nal_total_next    = nal_total;
    pos_next          = pos;
    strip_next        = strip;
    di_next           = di;
    is265_next        = is265;
    frag_next         = frag;
    payload_left_next = payload_left;
    frag_left_next    = frag_left;
    first_frag_next   = first_frag;
    nh0_next          = nh0;
    nh1_next          = nh1;
    idx_next          = idx;
    for (int i = 0; i < 4; i++) begin
      held_next[i] = held[i];
    end
    feed_en  = 1'b0;
    feed_b   = nal_byte;
    feed_idx = idx;
    feed_eor = 1'b1;
    dd       = di - strip;

    if (phase == rvnp_pkg::PH_DRAIN) begin
      feed_b   = held[di[1:0]];
      feed_idx = (dd >= 3'd2) ? 2'd2 : dd[1:0];
      feed_en  = !fifo_full;
      feed_eor = (di + 3'd1 == pos);
    end else if (acc && first_of_nal) begin
      nal_total_next = nal_length;
      pos_next       = 3'd0;
      phase_next     = (nal_length != 20'd0) ? rvnp_pkg::PH_SCAN : rvnp_pkg::PH_IDLE;
    end else if (acc && phase == rvnp_pkg::PH_BODY) begin
      feed_en = 1'b1;
    end

    if (acc && ((first_of_nal && nal_length != 20'd0) ||
                (!first_of_nal && phase == rvnp_pkg::PH_SCAN))) begin
      for (int i = 0; i < 4; i++) begin
        held_next[i] = hw[i];
      end
      pos_next = p;
      if (dec_ok) begin
        strip_next      = dec_s;
        di_next         = dec_s;
        frag_left_next  = 11'd0;
        first_frag_next = 1'b1;
        if (size == 20'd0) begin
          phase_next = rvnp_pkg::PH_IDLE;
        end else begin
          is265_next        = use_h265;
          frag_next         = (size > 20'(rvnp_pkg::PAYLOAD_MTU));
          payload_left_next = (size > 20'(rvnp_pkg::PAYLOAD_MTU)) ?
                              size - (use_h265 ? 20'd2 : 20'd1) : size;
          idx_next          = 2'd0;
          phase_next        = (p == dec_s) ? rvnp_pkg::PH_BODY : rvnp_pkg::PH_DRAIN;
        end
      end
    end

    if (feed_en) begin
      if (hdr_byte) begin
        if (feed_idx[0]) begin
          nh1_next = feed_b;
        end else begin
          nh0_next = feed_b;
        end
      end else begin
        payload_left_next = pl_dec;
        if (frag) begin
          frag_left_next  = fl_dec;
          first_frag_next = first_frag && !new_frag;
        end
      end
      if (phase == rvnp_pkg::PH_DRAIN) begin
        di_next = di + 3'd1;
        if (di + 3'd1 == pos) begin
          phase_next = rvnp_pkg::PH_BODY;
          idx_next   = (dd + 3'd1 >= 3'd2) ? 2'd2 : 2'(dd + 3'd1);
        end
      end else begin
        idx_next = (idx == 2'd2) ? 2'd2 : idx + 2'd1;
      end
      if (nal_done) begin
        phase_next = rvnp_pkg::PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= rvnp_pkg::PH_IDLE;
      nal_total    <= '0;
      pos          <= '0;
      strip        <= '0;
      di           <= '0;
      is265        <= 1'b0;
      frag         <= 1'b0;
      payload_left <= '0;
      frag_left    <= '0;
      first_frag   <= 1'b1;
      nh0          <= '0;
      nh1          <= '0;
      idx          <= '0;
      for (int i = 0; i < 4; i++) begin
        held[i] <= '0;
      end
    end else begin
      phase        <= phase_next;
      nal_total    <= nal_total_next;
      pos          <= pos_next;
      strip        <= strip_next;
      di           <= di_next;
      is265        <= is265_next;
      frag         <= frag_next;
      payload_left <= payload_left_next;
      frag_left    <= frag_left_next;
      first_frag   <= first_frag_next;
      nh0          <= nh0_next;
      nh1          <= nh1_next;
      idx          <= idx_next;
      for (int i = 0; i < 4; i++) begin
        held[i] <= held_next[i];
      end
    end
  end

endmodule

@@ hdl/rvnp_fifo.sv @@
// Command queue between front and back parts.
module rvnp_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rvnp_pkg::cmd_t wr_cmd,
  input  logic           pop,
  output rvnp_pkg::cmd_t rd_cmd,
  output logic           full,
  output logic           empty
);

  rvnp_pkg::cmd_t mem [rvnp_pkg::FIFO_DEPTH];
  logic [rvnp_pkg::FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [rvnp_pkg::FIFO_AW:0]   count;
  logic do_push, do_pop;

  assign full    = (count == (rvnp_pkg::FIFO_AW+1)'(rvnp_pkg::FIFO_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_cmd  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (rvnp_pkg::FIFO_AW+1)'(do_push) - (rvnp_pkg::FIFO_AW+1)'(do_pop);
    end
  end

endmodule

@@ hdl/rvnp_back.sv @@
// Back part: RTP header and FU header emission, output register.
module rvnp_back (
  input  logic                clk,
  input  logic                rst,
  input  rvnp_pkg::cmd_t      q_cmd,
  input  logic                q_empty,
  output logic                q_pop,
  input  rvnp_pkg::cnt_load_t cnt_load,
  input  logic [31:0]         ssrc,
  input  logic [31:0]         ts_increment,
  input  logic [6:0]          payload_type,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          packet_byte,
  output logic                end_of_packet,
  output logic                end_of_run
);

  rvnp_pkg::cmd_t cur;
  logic        cur_valid;
  logic [3:0]  pos;
  logic [15:0] seq;
  logic [31:0] ts;
  logic        adv, take;
  logic [7:0]  byte_sel;
  logic [3:0]  pos_after;

  assign adv   = !out_valid || !out_stall;
  assign take  = !cur_valid || (adv && pos == rvnp_pkg::POS_DATA);
  assign q_pop = take && !q_empty;

  always_comb begin
    pos_after = (pos == rvnp_pkg::POS_LAST_HDR) ?
                rvnp_pkg::POS_DATA - {2'd0, cur.fu_n} : pos + 4'd1;
    case (pos)
      4'd0:    byte_sel = rvnp_pkg::RTP_VERSION_BYTE;
      4'd1:    byte_sel = {cur.marker, payload_type};
      4'd2:    byte_sel = seq[15:8];
      4'd3:    byte_sel = seq[7:0];
      4'd4:    byte_sel = ts[31:24];
      4'd5:    byte_sel = ts[23:16];
      4'd6:    byte_sel = ts[15:8];
      4'd7:    byte_sel = ts[7:0];
      4'd8:    byte_sel = ssrc[31:24];
      4'd9:    byte_sel = ssrc[23:16];
      4'd10:   byte_sel = ssrc[15:8];
      4'd11:   byte_sel = ssrc[7:0];
      4'd12:   byte_sel = cur.fu0;
      4'd13:   byte_sel = cur.fu1;
      4'd14:   byte_sel = cur.fu2;
      default: byte_sel = cur.data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv && cur_valid) begin
      packet_byte   <= byte_sel;
      end_of_packet <= (pos == rvnp_pkg::POS_DATA) && cur.eop;
      end_of_run    <= (pos == rvnp_pkg::POS_DATA) && cur.eor;
    end
    if (q_pop) begin
      cur <= q_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cur_valid <= 1'b0;
      pos       <= '0;
      seq       <= '0;
      ts        <= '0;
    end else begin
      if (adv) begin
        out_valid <= cur_valid;
      end
      if (q_pop) begin
        cur_valid <= 1'b1;
        pos       <= q_cmd.hdr ? 4'd0 : rvnp_pkg::POS_DATA;
      end else if (take) begin
        cur_valid <= 1'b0;
      end else if (adv) begin
        pos <= pos_after;
      end
      if (cnt_load.seq_load) begin
        seq <= cnt_load.seq_value;
      end else if (adv && cur_valid && pos == rvnp_pkg::POS_LAST_HDR) begin
        seq <= seq + 16'd1;
      end
      if (cnt_load.ts_load) begin
        ts <= cnt_load.ts_value;
      end else if (adv && cur_valid && pos == rvnp_pkg::POS_DATA && cur.ts_step) begin
        ts <= ts + ts_increment;
      end
    end
  end

endmodule

@@ hdl/rtp_video_nal_packetizer.sv @@
// Top level of the RTP video NAL packetizer.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | nal_byte, nal_length, first_of_nal
//  out     | output    | out_valid / out_stall| packet_byte, end_of_packet, end_of_run
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Body bytes are taken one per cycle while in_stall is low; each packet adds 12 header bytes
// on the output side, and each fragment 2 (H.264) or 3 (H.265) FU header bytes more.
// Input stalls while held bytes are released after the start code decision.
// A four-entry command queue lets input run ahead while headers go out.
// Reset is synchronous; cfg_ready is always high.
module rtp_video_nal_packetizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  nal_byte,
  input  logic [19:0] nal_length,
  input  logic        first_of_nal,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  packet_byte,
  output logic        end_of_packet,
  output logic        end_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] ssrc;
  logic [31:0] ts_increment;
  logic        use_h265;
  logic [6:0]  payload_type;
  logic        cfg_we;
  rvnp_pkg::cnt_load_t cnt_load;
  rvnp_pkg::cmd_t f_cmd, q_cmd;
  logic f_push, q_pop, q_full, q_empty;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_comb begin
    cnt_load.seq_load  = cfg_we && (cfg_index == rvnp_pkg::CFG_INITIAL_SEQ);
    cnt_load.seq_value = cfg_data[15:0];
    cnt_load.ts_load   = cfg_we && (cfg_index == rvnp_pkg::CFG_INITIAL_TS);
    cnt_load.ts_value  = cfg_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ssrc         <= '0;
      ts_increment <= 32'd1500;
      use_h265     <= 1'b0;
      payload_type <= 7'd96;
    end else if (cfg_we) begin
      case (cfg_index)
        rvnp_pkg::CFG_SSRC:         ssrc         <= cfg_data;
        rvnp_pkg::CFG_TS_INCREMENT: ts_increment <= cfg_data;
        rvnp_pkg::CFG_USE_H265:     use_h265     <= cfg_data[0];
        rvnp_pkg::CFG_PAYLOAD_TYPE: payload_type <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  rvnp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .nal_byte     (nal_byte),
    .nal_length   (nal_length),
    .first_of_nal (first_of_nal),
    .use_h265     (use_h265),
    .fifo_full    (q_full),
    .push         (f_push),
    .cmd          (f_cmd)
  );

  rvnp_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (f_push),
    .wr_cmd (f_cmd),
    .pop    (q_pop),
    .rd_cmd (q_cmd),
    .full   (q_full),
    .empty  (q_empty)
  );

  rvnp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_cmd         (q_cmd),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .cnt_load      (cnt_load),
    .ssrc          (ssrc),
    .ts_increment  (ts_increment),
    .payload_type  (payload_type),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .packet_byte   (packet_byte),
    .end_of_packet (end_of_packet),
    .end_of_run    (end_of_run)
  );

endmodule

@@ hdl/rvnp_checker.sv @@
// Port-level checks for the packetizer, bound to the top level.
module rvnp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  packet_byte,
  input logic        end_of_packet,
  input logic        end_of_run
);

  logic at_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      at_start <= 1'b1;
    end else if (out_valid && !out_stall) begin
      at_start <= end_of_packet;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(packet_byte))
    else $error("stalled word changed");

  a_pkt_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && at_start |-> packet_byte == 8'h80)
    else $error("packet does not open with version byte");

  a_eop_eor: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_packet |-> end_of_run)
    else $error("packet end not at end of run");

  a_rst_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output word after reset");

endmodule

bind rtp_video_nal_packetizer rvnp_checker u_rvnp_checker (.*);

@@ tb/rtp_video_nal_packetizer_test.sv @@
// Self-checking testbench for the RTP video NAL packetizer: random NAL traffic against a predictor.
`timescale 1ns / 1ps
module rtp_video_nal_packetizer_test;

  typedef struct {
    logic [7:0]  b;
    logic [19:0] len;
    logic        first;
  } nal_word_t;

  typedef struct {
    logic [7:0] b;
    logic       eop;
    logic       eor;
  } pkt_word_t;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  localparam int MAX_NAL = 1048575;
  localparam int STEP_MAX = 17;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  nal_byte = 8'h00;
  logic [19:0] nal_length = 20'h0;
  logic        first_of_nal = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  packet_byte;
  logic        end_of_packet;
  logic        end_of_run;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  rvnp_pkg::cfg_index_t cfg_index = rvnp_pkg::CFG_SSRC;
  logic [31:0] cfg_data = 32'h0;

  nal_word_t  nal_pending[$];
  pkt_word_t  pkt_expected[$];
  pkt_word_t  step_q[$];
  idle_mode_t idle_mode = IDLE_NONE;
  int         errors = 0;
  int         pushed = 0;

  // predictor state
  logic [31:0] p_ssrc, p_ts_inc, p_pt, p_h265;
  logic [15:0] p_seq;
  logic [31:0] p_ts;
  logic [7:0]  p_held[4];
  logic [7:0]  p_nalhdr[2];
  int unsigned p_pos, p_strip, p_frag_left, p_pay_left, p_total;
  logic        p_first_frag, p_fragging, p_is_h265;
  rvnp_pkg::phase_t p_phase;

  rtp_video_nal_packetizer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .nal_byte(nal_byte), .nal_length(nal_length), .first_of_nal(first_of_nal),
    .out_valid(out_valid), .out_stall(out_stall),
    .packet_byte(packet_byte), .end_of_packet(end_of_packet), .end_of_run(end_of_run),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic put(input logic [7:0] b, input logic eop);
    if (step_q.size() < STEP_MAX) step_q.insert(step_q.size(), '{b, eop, 1'b0});
  endtask

  task automatic put_header(input logic marker);
    put(rvnp_pkg::RTP_VERSION_BYTE, 0);
    put({marker, p_pt[6:0]}, 0);
    put(p_seq[15:8], 0);
    put(p_seq[7:0], 0);
    put(p_ts[31:24], 0);
    put(p_ts[23:16], 0);
    put(p_ts[15:8], 0);
    put(p_ts[7:0], 0);
    put(p_ssrc[31:24], 0);
    put(p_ssrc[23:16], 0);
    put(p_ssrc[15:8], 0);
    put(p_ssrc[7:0], 0);
    p_seq = p_seq + 16'd1;
  endtask

  task automatic feed_body(input logic [7:0] b, input int unsigned idx);
    int unsigned hc, maxf;
    logic last;
    logic [7:0] flags, h0;
    if (!p_fragging) begin
      if (idx == 0) put_header(1'b1);
      put(b, p_pay_left == 1);
      p_pay_left--;
    end else begin
      hc = p_is_h265 ? 2 : 1;
      if (idx < hc) begin
        p_nalhdr[idx & 1] = b;
        return;
      end
      if (p_frag_left == 0) begin
        maxf = (rvnp_pkg::PAYLOAD_MTU > hc + 1) ? rvnp_pkg::PAYLOAD_MTU - 1 - hc : 1;
        last = p_pay_left <= maxf;
        flags = (p_first_frag ? 8'h80 : 8'h00) | (last ? 8'h40 : 8'h00);
        h0 = p_nalhdr[0];
        put_header(last);
        if (p_is_h265) begin
          put(rvnp_pkg::H265_FU_TYPE | (h0 & 8'h81), 0);
          put(p_nalhdr[1], 0);
          put(flags | ((h0 & 8'h7E) >> 1), 0);
        end else begin
          put((h0 & 8'hE0) | 8'(rvnp_pkg::H264_FU_A_TYPE), 0);
          put(flags | (h0 & 8'h1F), 0);
        end
        p_first_frag = 0;
        p_frag_left = last ? p_pay_left : maxf;
      end
      p_frag_left--;
      put(b, p_frag_left == 0);
      p_pay_left--;
    end
    if (p_pay_left == 0) begin
      p_ts = p_ts + p_ts_inc;
      p_phase = rvnp_pkg::PH_IDLE;
    end
  endtask

  function automatic int strip_len(input int unsigned p);
    if (p_held[0] != 0) return 0;
    if (p >= 2 && p_held[1] != 0) return 0;
    if (p >= 3) begin
      if (p_held[2] == 1) return 3;
      if (p_held[2] != 0) return 0;
      if (p >= 4) return p_held[3] == 1 ? 4 : 0;
    end
    if (p >= p_total) return 0;
    return -1;
  endfunction

  task automatic predict_packets(input nal_word_t w);
    int s;
    int unsigned size, i;
    step_q.delete();
    if (w.first) begin
      p_total = (w.len > MAX_NAL) ? MAX_NAL : w.len;
      p_pos = 0; p_strip = 0; p_frag_left = 0; p_pay_left = 0;
      p_first_frag = 1; p_fragging = 0;
      p_phase = p_total != 0 ? rvnp_pkg::PH_SCAN : rvnp_pkg::PH_IDLE;
    end
    if (p_phase == rvnp_pkg::PH_SCAN) begin
      p_held[p_pos & 3] = w.b;
      p_pos++;
      s = strip_len(p_pos);
      if (s >= 0) begin
        size = p_total - s;
        p_strip = s;
        if (size == 0) begin
          p_phase = rvnp_pkg::PH_IDLE;
        end else begin
          p_is_h265 = p_h265[0];
          p_fragging = size > rvnp_pkg::PAYLOAD_MTU;
          p_pay_left = p_fragging ? size - (p_is_h265 ? 2 : 1) : size;
          p_phase = rvnp_pkg::PH_BODY;
          for (i = p_strip; i < p_pos && p_phase == rvnp_pkg::PH_BODY; i++)
            feed_body(p_held[i & 3], i - p_strip);
        end
      end
    end else if (p_phase == rvnp_pkg::PH_BODY) begin
      feed_body(w.b, p_pos - p_strip);
      p_pos++;
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].eor = 1'b1;
    foreach (step_q[k]) pkt_expected.insert(pkt_expected.size(), step_q[k]);
  endtask

  function automatic logic sender_idles();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(0, 99) < 84;
      IDLE_BOTH:   return $urandom_range(0, 99) < 9;
      default:     return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) predict_packets('{nal_byte, nal_length, first_of_nal});
      if (nal_pending.size() > 0 && !sender_idles()) begin
        nal_word_t w;
        w = nal_pending.pop_front();
        in_valid <= 1'b1;
        nal_byte <= w.b;
        nal_length <= w.len;
        first_of_nal <= w.first;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pkt_expected.size() == 0) begin
          report($sformatf("unexpected word %h", packet_byte));
        end else begin
          pkt_word_t e;
          e = pkt_expected.pop_front();
          if (packet_byte !== e.b)
            report($sformatf("packet_byte %h, want %h", packet_byte, e.b));
          if (end_of_packet !== e.eop)
            report($sformatf("end_of_packet %b, want %b", end_of_packet, e.eop));
          if (end_of_run !== e.eor)
            report($sformatf("end_of_run %b, want %b", end_of_run, e.eor));
        end
      end
      case (idle_mode)
        IDLE_RECEIVER: out_stall <= $urandom_range(0, 99) < 84;
        IDLE_BOTH:     out_stall <= $urandom_range(0, 99) < 9;
        default:       out_stall <= 1'b0;
      endcase
    end
  end

  task automatic cfg_write(input rvnp_pkg::cfg_index_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      rvnp_pkg::CFG_SSRC:         p_ssrc = val;
      rvnp_pkg::CFG_INITIAL_SEQ:  p_seq = val[15:0];
      rvnp_pkg::CFG_INITIAL_TS:   p_ts = val;
      rvnp_pkg::CFG_TS_INCREMENT: p_ts_inc = val;
      rvnp_pkg::CFG_USE_H265:     p_h265 = {31'd0, val[0]};
      rvnp_pkg::CFG_PAYLOAD_TYPE: p_pt = {25'd0, val[6:0]};
      default: ;
    endcase
  endtask

  task automatic push_word(input logic [7:0] b, input logic [19:0] len, input logic first);
    nal_pending.insert(nal_pending.size(), '{b, len, first});
    pushed++;
  endtask

  // kind: 0 no start code, 1 three-byte, 2 four-byte, 3 near miss 00 00 02
  task automatic push_nal(input int kind, input int body, input int cut, input logic [19:0] len_o);
    logic [7:0] bytes[$];
    int n;
    logic [19:0] len;
    case (kind)
      1: bytes = '{8'h00, 8'h00, 8'h01};
      2: bytes = '{8'h00, 8'h00, 8'h00, 8'h01};
      3: bytes = '{8'h00, 8'h00, 8'h02};
      default: bytes = {};
    endcase
    repeat (body) bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
    len = len_o != 0 ? len_o : 20'(bytes.size());
    n = cut > 0 && cut < bytes.size() ? cut : bytes.size();
    for (int i = 0; i < n; i++) push_word(bytes[i], len, i == 0);
  endtask

  task automatic wait_idle();
    wait (nal_pending.size() == 0 && !in_valid && pkt_expected.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_traffic(input int count, input bit pause);
    int r, base;
    base = pushed;
    while (pushed - base < count) begin
      r = $urandom_range(0, 99);
      if (pause && pushed - base >= count / 2) begin
        wait (nal_pending.size() == 0 && !in_valid && pkt_expected.size() == 0);
        pause = 0;
      end
      if (r < 6) begin
        push_word(8'($urandom_range(0, 255)), 20'($urandom_range(0, 20'hFFFFF)), 1'b0);
      end else if (r < 14) begin
        push_nal($urandom_range(0, 3), $urandom_range(1, 12), $urandom_range(1, 5),
                 20'($urandom_range(1, 20'hFFFFF)));
      end else if (r < 17) begin
        push_word(8'h00, 20'd0, 1'b1);
      end else begin
        r = $urandom_range(1, 20);
        push_nal($urandom_range(0, 3), $urandom_range(0, 3) == 0 ? 1 : r, 0, 0);
      end
    end
  endtask

  initial begin
    p_ssrc = 0; p_seq = 0; p_ts = 0; p_ts_inc = 1500; p_h265 = 0; p_pt = 96;
    p_held = '{default: 8'h00}; p_nalhdr = '{default: 8'h00};
    p_pos = 0; p_strip = 0; p_frag_left = 0; p_pay_left = 0; p_total = 0;
    p_first_frag = 1; p_fragging = 0; p_is_h265 = 0; p_phase = rvnp_pkg::PH_IDLE;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_mode = IDLE_NONE;
    push_word(8'hFF, 20'hFFFFF, 1'b0);
    push_word(8'h00, 20'd0, 1'b1);
    push_nal(1, 3, 0, 0);
    push_nal(2, 2, 0, 0);
    push_nal(1, 0, 0, 0);
    push_nal(2, 0, 0, 0);
    push_word(8'h00, 20'd1, 1'b1);
    push_word(8'h00, 20'd2, 1'b1);
    push_word(8'h00, 20'd2, 1'b0);
    push_nal(3, 2, 0, 0);
    push_nal(2, 4, 3, 20'hFFFFF);
    push_nal(0, 1, 0, 0);
    random_traffic(80, 0);
    wait_idle();

    cfg_write(rvnp_pkg::CFG_SSRC, 32'hFFFF_FFFF);
    cfg_write(rvnp_pkg::CFG_INITIAL_SEQ, 32'h0000_FFFE);
    cfg_write(rvnp_pkg::CFG_INITIAL_TS, 32'hFFFF_FFF0);
    cfg_write(rvnp_pkg::CFG_TS_INCREMENT, 32'hFFFF_FFFF);
    cfg_write(rvnp_pkg::CFG_USE_H265, 32'd1);
    cfg_write(rvnp_pkg::CFG_PAYLOAD_TYPE, 32'd127);
    idle_mode = IDLE_SENDER;
    random_traffic(80, 1);
    wait_idle();

    cfg_write(rvnp_pkg::CFG_SSRC, 32'h0);
    cfg_write(rvnp_pkg::CFG_TS_INCREMENT, 32'h0);
    cfg_write(rvnp_pkg::CFG_PAYLOAD_TYPE, 32'h0);
    cfg_write(rvnp_pkg::CFG_USE_H265, 32'd0);
    idle_mode = IDLE_RECEIVER;
    random_traffic(80, 0);
    wait_idle();

    cfg_write(rvnp_pkg::CFG_SSRC, $urandom);
    cfg_write(rvnp_pkg::CFG_INITIAL_SEQ, $urandom);
    cfg_write(rvnp_pkg::CFG_INITIAL_TS, $urandom);
    cfg_write(rvnp_pkg::CFG_TS_INCREMENT, $urandom);
    cfg_write(rvnp_pkg::CFG_USE_H265, 32'd1);
    cfg_write(rvnp_pkg::CFG_PAYLOAD_TYPE, 32'($urandom_range(0, 127)));
    idle_mode = IDLE_BOTH;
    random_traffic(80, 0);

    wait (nal_pending.size() == 0 && !in_valid && pkt_expected.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0 && pkt_expected.size() == 0) begin
      $display("rtp_video_nal_packetizer regression: pass");
    end else begin
      $display("rtp_video_nal_packetizer regression: fail");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("rtp_video_nal_packetizer regression: fail");
    $finish;
  end

endmodule
